// ----- hw/rtl/timed_frame_sequencer_macros.svh -----
// assertion macros shared by the frame sequencer rtl
`ifndef TIMED_FRAME_SEQUENCER_MACROS_SVH
`define TIMED_FRAME_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TFS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tfs_pkg.sv -----
// shared constants, codes and types of the frame sequencer
`default_nettype none

package tfs_pkg;

    // table depth and number of known clips
    localparam int MAX_FRAMES = 32;
    localparam int ANIM_COUNT = 16;

    // opcodes of an input word
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PLAY  = 2'd2;
    localparam logic [1:0] OP_TAKE  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    // one input word
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] elapsed_ms;
        logic [4:0]  frame_slot;
        logic [15:0] duration_value;
        logic [7:0]  anim_id;
        logic [5:0]  clip_frames;
        logic        loop_clip;
    } item_t;

    // one result word
    typedef struct packed {
        logic [1:0]  status;
        logic        frame_valid;
        logic [4:0]  frame_pos;
        logic [15:0] frame_duration;
        logic        is_playing;
        logic [7:0]  current_anim;
        logic        completed;
        logic [7:0]  done_anim;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       tick_add;
        logic       step;
        logic       wr_dur;
        logic       chk_clear;
        logic       chk_inc;
        logic       sel_chk;
        logic       commit;
        logic       take;
        logic       res_load;
        logic [1:0] res_status;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       slot_bad;
        logic [1:0] play_code;
        logic       step_brk;
        logic       chk_zero;
        logic       chk_last;
        logic       out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tfs_ifs.sv -----
// valid/ready channels for input and result words
`default_nettype none

interface tfs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] elapsed_ms;
    logic [4:0]  frame_slot;
    logic [15:0] duration_value;
    logic [7:0]  anim_id;
    logic [5:0]  clip_frames;
    logic        loop_clip;

    modport source (
        output valid, opcode, elapsed_ms, frame_slot, duration_value,
               anim_id, clip_frames, loop_clip,
        input  ready
    );
    modport sink (
        input  valid, opcode, elapsed_ms, frame_slot, duration_value,
               anim_id, clip_frames, loop_clip,
        output ready
    );
endinterface

interface tfs_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        frame_valid;
    logic [4:0]  frame_pos;
    logic [15:0] frame_duration;
    logic        is_playing;
    logic [7:0]  current_anim;
    logic        completed;
    logic [7:0]  done_anim;

    modport source (
        output valid, status, frame_valid, frame_pos, frame_duration,
               is_playing, current_anim, completed, done_anim,
        input  ready
    );
    modport sink (
        input  valid, status, frame_valid, frame_pos, frame_duration,
               is_playing, current_anim, completed, done_anim,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/tfs_datapath.sv -----
// duration table, playback state, step logic and result register
`default_nettype none

module tfs_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  tfs_pkg::item_t   item,
    input  tfs_pkg::dp_cmd_t cmd,
    input  logic             rsp_ready,
    output tfs_pkg::dp_sts_t sts,
    output tfs_pkg::result_t res,
    output logic             res_valid
);
    import tfs_pkg::*;

    // duration table, cleared at reset
    logic [15:0] dur_tbl_reg [MAX_FRAMES];

    // playback state
    logic [4:0]  pos_reg,     pos_next;
    logic [16:0] tif_reg,     tif_next;
    logic        playing_reg, playing_next;
    logic        pending_reg, pending_next;
    logic        loaded_reg,  loaded_next;
    logic        loop_reg,    loop_next;
    logic [7:0]  anim_reg,    anim_next;
    logic [5:0]  len_reg,     len_next;

    // work registers
    logic [5:0]  zrun_reg,    zrun_next;
    logic [4:0]  chk_reg,     chk_next;
    logic        comp_reg,    comp_next;
    logic [7:0]  comp_id_reg, comp_id_next;
    item_t       item_reg,    item_next;
    result_t     res_reg,     res_next;
    logic        res_vld_reg, res_vld_next;

    logic [4:0]  rd_addr;
    logic [15:0] rd_dur;
    logic [16:0] dur_ext;
    logic [6:0]  zrun_inc;
    logic [5:0]  pos_inc;
    logic        zrun_over;

    // single table read, scan index or current frame
    assign rd_addr = cmd.sel_chk ? chk_reg : pos_reg;
    assign rd_dur  = dur_tbl_reg[rd_addr];
    assign dur_ext = {1'b0, rd_dur};

    // step decision terms
    assign zrun_inc  = {1'b0, zrun_reg} + 7'd1;
    assign pos_inc   = {1'b0, pos_reg} + 6'd1;
    assign zrun_over = (rd_dur == 16'd0) && (zrun_inc > {1'b0, len_reg});

    // status toward the controller
    always_comb
    begin
        sts.op       = item_reg.opcode;
        sts.slot_bad = ({1'b0, item_reg.frame_slot} >= 6'(MAX_FRAMES));
        if (item_reg.anim_id >= 8'(ANIM_COUNT))
            sts.play_code = ST_INVAL;
        else if (item_reg.clip_frames == 6'd0)
            sts.play_code = ST_UNSUP;
        else if ({1'b0, item_reg.clip_frames} > 7'(MAX_FRAMES))
            sts.play_code = ST_INVAL;
        else
            sts.play_code = ST_OK;
        sts.step_brk = !playing_reg || (tif_reg < dur_ext) || zrun_over;
        sts.chk_zero = (rd_dur == 16'd0);
        sts.chk_last = (({1'b0, chk_reg} + 6'd1) == item_reg.clip_frames);
        sts.out_free = !res_vld_reg || rsp_ready;
    end

    // next-state logic
    always_comb
    begin
        pos_next     = pos_reg;
        tif_next     = tif_reg;
        playing_next = playing_reg;
        pending_next = pending_reg;
        loaded_next  = loaded_reg;
        loop_next    = loop_reg;
        anim_next    = anim_reg;
        len_next     = len_reg;
        zrun_next    = zrun_reg;
        chk_next     = chk_reg;
        comp_next    = comp_reg;
        comp_id_next = comp_id_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        res_vld_next = res_vld_reg;

        // latch the word, clear take report
        if (cmd.capture)
        begin
            item_next    = item;
            comp_next    = 1'b0;
            comp_id_next = 8'd0;
        end

        // add elapsed time, wraps at 17 bits even while stopped
        if (cmd.tick_add)
        begin
            tif_next  = tif_reg + {1'b0, item_reg.elapsed_ms};
            zrun_next = 6'd0;
        end

        // one frame step
        if (cmd.step)
        begin
            zrun_next = (rd_dur == 16'd0) ? zrun_inc[5:0] : 6'd0;
            tif_next  = tif_reg - dur_ext;
            if (pos_inc < len_reg)
                pos_next = pos_inc[4:0];
            else if (loop_reg)
                pos_next = 5'd0;
            else
            begin
                playing_next = 1'b0;
                pending_next = 1'b1;
                tif_next     = 17'd0;
            end
        end

        // duration scan index
        if (cmd.chk_clear)
            chk_next = 5'd0;
        else if (cmd.chk_inc)
            chk_next = chk_reg + 5'd1;

        // start the clip
        if (cmd.commit)
        begin
            loaded_next  = 1'b1;
            anim_next    = item_reg.anim_id;
            len_next     = item_reg.clip_frames;
            loop_next    = item_reg.loop_clip;
            pos_next     = 5'd0;
            tif_next     = 17'd0;
            playing_next = 1'b1;
            pending_next = 1'b0;
        end

        // take the completion flag
        if (cmd.take)
        begin
            comp_next    = pending_reg;
            comp_id_next = pending_reg ? anim_reg : 8'd0;
            pending_next = 1'b0;
        end

        // result register
        if (res_vld_reg && rsp_ready)
            res_vld_next = 1'b0;
        if (cmd.res_load)
        begin
            res_vld_next            = 1'b1;
            res_next.status         = cmd.res_status;
            res_next.frame_valid    = loaded_reg;
            res_next.frame_pos      = loaded_reg ? pos_reg : 5'd0;
            res_next.frame_duration = loaded_reg ? rd_dur : 16'd0;
            res_next.is_playing     = playing_reg;
            res_next.current_anim   = anim_reg;
            res_next.completed      = comp_reg;
            res_next.done_anim      = comp_id_reg;
        end
    end

    // duration table writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
                dur_tbl_reg[i] <= 16'd0;
        end
        else if (cmd.wr_dur && !sts.slot_bad)
        begin
            dur_tbl_reg[item_reg.frame_slot] <= item_reg.duration_value;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 5'd0;
            tif_reg     <= 17'd0;
            playing_reg <= 1'b0;
            pending_reg <= 1'b0;
            loaded_reg  <= 1'b0;
            loop_reg    <= 1'b0;
            anim_reg    <= 8'(ANIM_COUNT);
            len_reg     <= 6'd0;
            zrun_reg    <= 6'd0;
            chk_reg     <= 5'd0;
            comp_reg    <= 1'b0;
            comp_id_reg <= 8'd0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            tif_reg     <= tif_next;
            playing_reg <= playing_next;
            pending_reg <= pending_next;
            loaded_reg  <= loaded_next;
            loop_reg    <= loop_next;
            anim_reg    <= anim_next;
            len_reg     <= len_next;
            zrun_reg    <= zrun_next;
            chk_reg     <= chk_next;
            comp_reg    <= comp_next;
            comp_id_reg <= comp_id_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = res_vld_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tfs_ctrl.sv -----
// controller state machine of the frame sequencer
`default_nettype none

module tfs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  tfs_pkg::dp_sts_t sts,
    output logic             in_ready,
    output tfs_pkg::dp_cmd_t cmd
);
    import tfs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_STEP   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg,  state_next;
    logic [1:0] status_reg, status_next;

    // sequencing and command decode
    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        cmd            = '0;
        cmd.res_status = status_reg;
        in_ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = ST_OK;
                state_next  = S_RESULT;
                case (sts.op)
                    OP_TICK:
                    begin
                        cmd.tick_add = 1'b1;
                        state_next   = S_STEP;
                    end
                    OP_WRITE:
                    begin
                        cmd.wr_dur  = 1'b1;
                        status_next = sts.slot_bad ? ST_INVAL : ST_OK;
                    end
                    OP_PLAY:
                    begin
                        if (sts.play_code != ST_OK)
                            status_next = sts.play_code;
                        else
                        begin
                            cmd.chk_clear = 1'b1;
                            state_next    = S_CHECK;
                        end
                    end
                    OP_TAKE:
                    begin
                        cmd.take = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            // a frame per cycle while playing and time due
            S_STEP:
            begin
                if (sts.step_brk)
                    state_next = S_RESULT;
                else
                    cmd.step = 1'b1;
            end
            // scan the clip durations for a zero entry
            S_CHECK:
            begin
                cmd.sel_chk = 1'b1;
                if (sts.chk_zero)
                begin
                    status_next = ST_INVAL;
                    state_next  = S_RESULT;
                end
                else if (sts.chk_last)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_RESULT;
                end
                else
                    cmd.chk_inc = 1'b1;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/timed_frame_sequencer.sv -----
// top level of the timed frame sequencer
`default_nettype none
`include "timed_frame_sequencer_macros.svh"

// Steps through the frames of one animation clip using a 32-entry table of
// frame durations in milliseconds, cleared at reset (no clearing pass). Opcode
// 0 adds elapsed time and advances, 1 writes a table entry, 2 starts a clip
// after checking its id, length and durations, 3 takes the completion flag.
// One word in gives one result word out. Words are handled one at a time:
// write and take go from decode straight to the result state, a tick steps
// over each frame whose time has run out (one frame per cycle through the
// shared compare/subtract step), and a play checks the clip's table entries
// (one table entry checked per cycle) before its result is loaded. A new
// word is accepted as soon as the controller is idle again, while the
// previous result may still wait in the output register.
module timed_frame_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    tfs_req_if.sink          req,
    tfs_rsp_if.source        rsp
);
    import tfs_pkg::*;

    item_t   item;
    result_t res;
    logic    res_valid;
    logic    in_ready;
    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // input word gathered from the channel
    always_comb
    begin
        item.opcode         = req.opcode;
        item.elapsed_ms     = req.elapsed_ms;
        item.frame_slot     = req.frame_slot;
        item.duration_value = req.duration_value;
        item.anim_id        = req.anim_id;
        item.clip_frames    = req.clip_frames;
        item.loop_clip      = req.loop_clip;
    end

    assign req.ready = in_ready;

    tfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .sts      (dp_sts),
        .in_ready (in_ready),
        .cmd      (dp_cmd)
    );

    tfs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (dp_cmd),
        .rsp_ready (rsp.ready),
        .sts       (dp_sts),
        .res       (res),
        .res_valid (res_valid)
    );

    // result word onto the channel
    assign rsp.valid          = res_valid;
    assign rsp.status         = res.status;
    assign rsp.frame_valid    = res.frame_valid;
    assign rsp.frame_pos      = res.frame_pos;
    assign rsp.frame_duration = res.frame_duration;
    assign rsp.is_playing     = res.is_playing;
    assign rsp.current_anim   = res.current_anim;
    assign rsp.completed      = res.completed;
    assign rsp.done_anim      = res.done_anim;

    // checks
    `TFS_ASSERT_IMPL(a_load_free, dp_cmd.res_load, dp_sts.out_free, "result loaded over a waiting word")
    `TFS_ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready, "word accepted while busy")
    `TFS_ASSERT_IMPL(a_done_stopped, rsp.valid && rsp.completed, !rsp.is_playing, "completion while playing")

endmodule

`default_nettype wire
